// ===== hw/rtl/extension_field_multiplier_unit_macros.svh =====
// Assertion macros for the extension field multiplier unit
`ifndef EXTENSION_FIELD_MULTIPLIER_UNIT_MACROS_SVH
`define EXTENSION_FIELD_MULTIPLIER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define EFM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define EFM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/efm_pkg.sv =====
// Shared constants and coefficient arithmetic for the extension field multiplier
`timescale 1ns / 1ps
`default_nettype none
package efm_pkg;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 64;
    localparam int DEG_W   = 4;
    localparam int CIDX_W  = 2;

    typedef enum logic [CIDX_W-1:0] {
        REG_PRIME   = 2'd0,
        REG_DEGREE  = 2'd1,
        REG_MODULUS = 2'd2,
        REG_SPARE   = 2'd3
    } cfg_reg_t;

    // eight restoring steps: remainder of (rem_in * 256 + bits) mod p, rem_in < p
    function automatic logic [BYTE_W-1:0] mod_chunk(input logic [BYTE_W-1:0] rem_in,
                                                    input logic [BYTE_W-1:0] bits,
                                                    input logic [BYTE_W-1:0] p);
        logic [BYTE_W:0] acc;
        acc = {1'b0, rem_in};
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            acc = {acc[BYTE_W-1:0], bits[i]};
            if (acc >= {1'b0, p}) begin
                acc = acc - {1'b0, p};
            end
        end
        return acc[BYTE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/extension_field_multiplier_unit.sv =====
// Top level: pipelined GF(p^d) multiplier with reduction by a monic modulus
// Pipeline: operand register, schoolbook product, top-coefficient reduction and fold stages,
//   final mod-p stages over the accumulator bytes, output register.
// Throughput: one transfer per cycle; the whole pipeline advances unless the output
//   register holds a result that is not taken.
// Reset: synchronous active-low aresetn clears all valid bits and loads p = 2, d = 1, f = 0.
`timescale 1ns / 1ps
`default_nettype none
`include "extension_field_multiplier_unit_macros.svh"
module extension_field_multiplier_unit #(
    parameter int MAX_DEGREE = 8,
    parameter int COEF_WIDTH = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [efm_pkg::CIDX_W-1:0]        cfg_index,
    input  wire logic [efm_pkg::DATA_W-1:0]        cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [efm_pkg::DATA_W-1:0]        s_a_coeffs,
    input  wire logic [efm_pkg::DATA_W-1:0]        s_b_coeffs,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [efm_pkg::DATA_W-1:0]             m_product_coeffs,
    output logic signed [efm_pkg::DEG_W-1:0]       m_product_degree
);

    localparam int BW    = efm_pkg::BYTE_W;
    localparam int NL    = 2 * MAX_DEGREE;
    localparam int ACC_W = 2 * BW + $clog2(NL);
    localparam int NCH   = (ACC_W + BW - 1) / BW;
    localparam int RWP   = NCH * BW;
    localparam int NRED  = (MAX_DEGREE - 1) * (NCH + 1);
    localparam int NST   = 1 + NRED + NCH;
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int KW    = $clog2(NL);
    localparam int IW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam logic [BW-1:0] COEF_MASK = BW'((1 << COEF_WIDTH) - 1);

    typedef logic [NL-1:0][RWP-1:0]       lanes_t;
    typedef logic [MAX_DEGREE-1:0][BW-1:0] coefs_t;

    // configuration
    logic [BW-1:0]                prime_reg;
    logic [efm_pkg::DEG_W-1:0]    degree_reg;
    logic [efm_pkg::DATA_W-1:0]   modulus_reg;
    logic [BW-1:0]                p_eff;
    logic [DW-1:0]                d_eff;
    coefs_t                       nf_reg, nf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg   <= 8'd2;
            degree_reg  <= 4'd1;
            modulus_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (efm_pkg::cfg_reg_t'(cfg_index))
                efm_pkg::REG_PRIME:   prime_reg   <= cfg_data[BW-1:0];
                efm_pkg::REG_DEGREE:  degree_reg  <= cfg_data[efm_pkg::DEG_W-1:0];
                efm_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        p_eff = (prime_reg < 8'd2) ? 8'd2 : prime_reg;
        if (degree_reg == '0) begin
            d_eff = DW'(1);
        end else if (degree_reg > efm_pkg::DEG_W'(MAX_DEGREE)) begin
            d_eff = DW'(MAX_DEGREE);
        end else begin
            d_eff = DW'(degree_reg);
        end
    end

    // negated modulus coefficients p - f_i, kept registered
    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            if (i < int'(d_eff)) begin
                nf_next[i] = p_eff - efm_pkg::mod_chunk('0, modulus_reg[BW*i +: BW] & COEF_MASK,
                                                        p_eff);
            end else begin
                nf_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        nf_reg <= nf_next;
    end

    // pipeline control
    logic              en;
    logic              v1_reg;
    logic [NST-1:0]    v_reg;
    logic              m_valid_reg;
    coefs_t            av_reg, bv_reg, av_next, bv_next;
    lanes_t            r_reg  [NST];
    lanes_t            r_next [NST];
    coefs_t            q_reg  [NST];
    coefs_t            q_next [NST];

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    // operand coefficients reduced mod p
    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            if (i < int'(d_eff)) begin
                av_next[i] = efm_pkg::mod_chunk('0, s_a_coeffs[BW*i +: BW] & COEF_MASK, p_eff);
                bv_next[i] = efm_pkg::mod_chunk('0, s_b_coeffs[BW*i +: BW] & COEF_MASK, p_eff);
            end else begin
                av_next[i] = '0;
                bv_next[i] = '0;
            end
        end
    end

    // schoolbook product, unreduced accumulation
    always_comb begin
        r_next[0] = '0;
        q_next[0] = '0;
        for (int i = 0; i < MAX_DEGREE; i++) begin
            for (int j = 0; j < MAX_DEGREE; j++) begin
                r_next[0][i+j] = r_next[0][i+j] + RWP'(16'(av_reg[i]) * 16'(bv_reg[j]));
            end
        end
    end

    for (genvar g = 1; g < NST; g++) begin : g_stage
        lanes_t r_nx;
        coefs_t q_nx;
        if (g <= NRED) begin : g_red
            localparam int S  = (g - 1) / (NCH + 1);
            localparam int PH = (g - 1) % (NCH + 1);
            if (PH < NCH) begin : g_mod
                // top coefficient mod p, one byte per stage
                logic [KW-1:0] kk;
                always_comb begin
                    kk   = KW'(2 * int'(d_eff) - 2 - S);
                    r_nx = r_reg[g-1];
                    q_nx = q_reg[g-1];
                    if (S < int'(d_eff) - 1) begin
                        q_nx[0] = efm_pkg::mod_chunk((PH == 0) ? '0 : q_reg[g-1][0],
                                                     r_reg[g-1][kk][RWP-1-BW*PH -: BW], p_eff);
                    end
                end
            end else begin : g_mac
                // fold c * x^k into the lower terms using p - f
                always_comb begin
                    int off;
                    r_nx = r_reg[g-1];
                    q_nx = q_reg[g-1];
                    for (int t = 0; t < NL; t++) begin
                        off = t - (int'(d_eff) - 2 - S);
                        if (S < int'(d_eff) - 1 && off >= 0 && off < int'(d_eff)) begin
                            r_nx[t] = r_reg[g-1][t]
                                    + RWP'(16'(q_reg[g-1][0]) * 16'(nf_reg[IW'(off)]));
                        end
                    end
                end
            end
        end else begin : g_fin
            localparam int FC = g - 1 - NRED;
            always_comb begin
                r_nx = r_reg[g-1];
                for (int i = 0; i < MAX_DEGREE; i++) begin
                    q_nx[i] = efm_pkg::mod_chunk((FC == 0) ? '0 : q_reg[g-1][i],
                                                 r_reg[g-1][i][RWP-1-BW*FC -: BW], p_eff);
                end
            end
        end
        assign r_next[g] = r_nx;
        assign q_next[g] = q_nx;
    end

    // result packing
    logic [efm_pkg::DATA_W-1:0]          prod_next, prod_reg;
    logic signed [efm_pkg::DEG_W-1:0]    deg_next, deg_reg;

    always_comb begin
        prod_next = '0;
        deg_next  = -4'sd1;
        for (int i = 0; i < MAX_DEGREE; i++) begin
            if (i < int'(d_eff)) begin
                prod_next[BW*i +: BW] = q_reg[NST-1][i];
                if (q_reg[NST-1][i] != '0) begin
                    deg_next = efm_pkg::DEG_W'(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v_reg       <= {v_reg[NST-2:0], v1_reg};
            m_valid_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            av_reg   <= av_next;
            bv_reg   <= bv_next;
            prod_reg <= prod_next;
            deg_reg  <= deg_next;
            for (int g = 0; g < NST; g++) begin
                r_reg[g] <= r_next[g];
                q_reg[g] <= q_next[g];
            end
        end
    end

    assign m_product_coeffs = prod_reg;
    assign m_product_degree = deg_reg;

    `EFM_ASSERT_NOW(a_deg_zero, aclk, aresetn, m_valid_reg, (m_product_degree == -4'sd1) == (m_product_coeffs == '0))
    `EFM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !en, $stable(v_reg) && $stable(v1_reg))
    `EFM_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v1_reg)

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the GF(p^d) polynomial-basis multiplier unit
`timescale 1ns / 1ps
module tb;

    localparam int MAXD = 8;
    localparam int LATENCY = 33;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [efm_pkg::CIDX_W-1:0] cfg_index = efm_pkg::REG_PRIME;
    logic [efm_pkg::DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [efm_pkg::DATA_W-1:0] s_a_coeffs = '0;
    logic [efm_pkg::DATA_W-1:0] s_b_coeffs = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [efm_pkg::DATA_W-1:0] m_product_coeffs;
    logic signed [efm_pkg::DEG_W-1:0] m_product_degree;

    typedef struct packed {
        logic [efm_pkg::DATA_W-1:0] coeffs;
        logic [efm_pkg::DEG_W-1:0] degree;
    } product_t;

    product_t pending_products[$];
    logic [7:0] fld_prime = 8'd2;
    logic [3:0] fld_degree = 4'd1;
    logic [efm_pkg::DATA_W-1:0] fld_modulus = '0;
    int errors = 0;
    int sent = 0;
    int received = 0;
    int idle_pct = 26;
    int quiet_cycles = 0;

    extension_field_multiplier_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_coeffs(s_a_coeffs), .s_b_coeffs(s_b_coeffs),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_product_coeffs(m_product_coeffs), .m_product_degree(m_product_degree)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic product_t field_product(logic [efm_pkg::DATA_W-1:0] a,
                                               logic [efm_pkg::DATA_W-1:0] b);
        int unsigned p, d, c, sub;
        int unsigned av[MAXD], bv[MAXD], fv[MAXD];
        int unsigned r[2*MAXD];
        int deg;
        product_t res;
        p = (fld_prime < 2) ? 2 : fld_prime;
        d = (fld_degree < 1) ? 1 : ((fld_degree > MAXD) ? MAXD : fld_degree);
        for (int i = 0; i < MAXD; i++) begin
            av[i] = (i < d) ? a[8*i +: 8] % p : 0;
            bv[i] = (i < d) ? b[8*i +: 8] % p : 0;
            fv[i] = (i < d) ? fld_modulus[8*i +: 8] % p : 0;
        end
        for (int k = 0; k < 2*MAXD; k++) r[k] = 0;
        for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++)
                r[i+j] = (r[i+j] + av[i] * bv[j]) % p;
        for (int k = 2*d - 2; k >= int'(d); k--) begin
            c = r[k];
            if (c != 0) begin
                for (int i = 0; i < d; i++) begin
                    sub = (c * fv[i]) % p;
                    r[k-d+i] = (r[k-d+i] + p - sub) % p;
                end
                r[k] = 0;
            end
        end
        res.coeffs = '0;
        deg = -1;
        for (int i = 0; i < d; i++) begin
            res.coeffs[8*i +: 8] = r[i][7:0];
            if (r[i] != 0) deg = i;
        end
        res.degree = deg[3:0];
        return res;
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                received <= received + 1;
                if (pending_products.size() == 0) begin
                    $error("unexpected result: coeffs %h degree %0d",
                           m_product_coeffs, m_product_degree);
                    errors++;
                end else begin
                    product_t exp_p;
                    exp_p = pending_products.pop_front();
                    if (m_product_coeffs !== exp_p.coeffs) begin
                        $error("product_coeffs: expected %h, got %h",
                               exp_p.coeffs, m_product_coeffs);
                        errors++;
                    end
                    if (m_product_degree !== exp_p.degree) begin
                        $error("product_degree: expected %0d, got %0d",
                               $signed(exp_p.degree), m_product_degree);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("extension_field_multiplier_unit: mismatch");
            $finish;
        end
    end

    task automatic send_operands(logic [efm_pkg::DATA_W-1:0] a,
                                 logic [efm_pkg::DATA_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_a_coeffs <= a;
        s_b_coeffs <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_products.push_back(field_product(a, b));
        sent++;
    endtask

    task automatic write_reg(efm_pkg::cfg_reg_t idx, logic [efm_pkg::DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        case (idx)
            efm_pkg::REG_PRIME: fld_prime = value[7:0];
            efm_pkg::REG_DEGREE: fld_degree = value[3:0];
            efm_pkg::REG_MODULUS: fld_modulus = value;
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_field(logic [7:0] p, logic [3:0] d, logic [efm_pkg::DATA_W-1:0] f);
        drain_pipeline();
        write_reg(efm_pkg::REG_PRIME, {56'h0, p});
        write_reg(efm_pkg::REG_DEGREE, {60'h0, d});
        write_reg(efm_pkg::REG_MODULUS, f);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [efm_pkg::DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // operand coefficients below p in every byte for most draws, raw noise otherwise
    function automatic logic [efm_pkg::DATA_W-1:0] rand_elem(logic [7:0] p);
        logic [efm_pkg::DATA_W-1:0] w;
        int unsigned pe;
        pe = (p < 2) ? 2 : p;
        if ($urandom_range(9) == 0) return rand_word();
        for (int i = 0; i < MAXD; i++) w[8*i +: 8] = 8'($urandom_range(pe - 1));
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_operands(64'h1, 64'h1);
        send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operands('0, 64'h3);
    endtask

    task automatic test_directed();
        set_field(8'd251, 4'd8, 64'h0000_0000_0000_0001);
        send_operands(64'hFAFA_FAFA_FAFA_FAFA, 64'hFAFA_FAFA_FAFA_FAFA);
        send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'h0101_0101_0101_0101);
        send_operands('0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operands(64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000);
        set_field(8'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operands(64'hFF, 64'hFF);
        send_operands(64'hFE, 64'h01);
        set_field(8'd1, 4'd15, 64'hAAAA_5555_AAAA_5555);
        send_operands(64'h5555_AAAA_5555_AAAA, 64'hFFFF_0000_FFFF_0000);
        send_operands(64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101);
        set_field(8'd255, 4'd9, 64'h8040_2010_0804_0201);
        send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'h7F7F_7F7F_7F7F_7F7F);
        send_operands(64'h8000_0000_0000_0080, 64'h0000_0000_0000_0080);
        set_field(8'd15, 4'd4, 64'hFFFF_FFFF_0302_0001);
        send_operands(64'hFFFF_FFFF_0E0E_0E0E, 64'h0000_0000_0102_0304);
        send_operands(64'h0000_0000_0000_0002, 64'h0000_0000_0000_0008);
    endtask

    task automatic test_random_fields();
        logic [7:0] primes[8] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd13, 8'd31, 8'd127, 8'd251};
        logic [7:0] p;
        logic [3:0] d;
        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(3))
                0: p = 8'($urandom_range(255));
                default: p = primes[$urandom_range(7)];
            endcase
            d = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
            set_field(p, d, (phase % 3 == 0) ? rand_word() : rand_elem(p));
            idle_pct = (phase == 6) ? 0 : 26;
            for (int n = 0; n < 100; n++) send_operands(rand_elem(p), rand_elem(p));
        end
        idle_pct = 26;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_random_fields();
        drain_pipeline();
        $display("covered %0d products over fields of varied prime, degree and modulus,", sent);
        $display("including out-of-range settings; %0d results checked", received);
        if (errors == 0) begin
            $display("extension_field_multiplier_unit: match");
        end else begin
            $display("extension_field_multiplier_unit: mismatch");
        end
        $finish;
    end
endmodule

// ===== extension_field_multiplier_unit.f =====
+incdir+hw/rtl
hw/rtl/efm_pkg.sv
hw/rtl/extension_field_multiplier_unit.sv
sim/tb.sv
